// File: design/rmfh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmfh_pkg;

    // Width of a thread identifier and of the status code.
    localparam int ID_W     = 8;
    localparam int STATUS_W = 3;

    // Request kinds.
    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED       = 3'd0,
        ST_BLOCKED       = 3'd1,
        ST_STILL_HELD    = 3'd2,
        ST_FREED         = 3'd3,
        ST_HANDED        = 3'd4,
        ST_NOT_HOLDER    = 3'd5,
        ST_QUEUE_FULL    = 3'd6,
        ST_NEST_OVERFLOW = 3'd7
    } status_t;

    // Controller states.
    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_EXEC = 1'b1
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_stall;
    } dp_status_t;

endpackage

`default_nettype wire

// File: design/rmfh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rmfh_ctrl
    import rmfh_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  dp_status_t      dp_status,
    output ctrl_cmd_t       cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands. A request is taken in idle, and it is
    // executed once the result register is free to take its result.
    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            CS_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = CS_EXEC;
                end
            end
            CS_EXEC: begin
                if (!dp_status.out_stall) begin
                    cmd.execute = 1'b1;
                    state_next  = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/rmfh_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rmfh_datapath
    import rmfh_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int NEST_BITS   = 8
)
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  ctrl_cmd_t                cmd,
    output dp_status_t               dp_status,
    input  wire logic                s_req_type,
    input  wire logic [ID_W-1:0]     s_requester_id,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic                     m_wake_valid,
    output logic [ID_W-1:0]          m_wake_id,
    output logic [ID_W-1:0]          m_holder_out,
    output logic                     m_is_locked
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    // Captured request.
    logic            req_type_reg;
    logic [ID_W-1:0] req_id_reg;

    // Lock state.
    logic                 locked_reg, locked_next;
    logic [ID_W-1:0]      holder_reg, holder_next;
    logic [NEST_BITS-1:0] nest_reg, nest_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    // Waiter queue memory and its registered read port at the head.
    logic [ID_W-1:0] queue_mem [QUEUE_DEPTH];
    logic [ID_W-1:0] head_data_reg;
    logic            push;

    // Result register.
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic                out_wake_valid_reg;
    logic [ID_W-1:0]     out_wake_id_reg;
    logic [ID_W-1:0]     out_holder_reg;
    logic                out_locked_reg;

    status_t             status_c;
    logic                wake_valid_c;
    logic [ID_W-1:0]     wake_id_c;
    logic                is_holder;

    // Request capture.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_type_reg <= s_req_type;
            req_id_reg   <= s_requester_id;
        end
    end

    // The head entry is read every cycle; the pointer and the memory are
    // stable in idle, so the data is current when a request is executed.
    always_ff @(posedge aclk) begin
        head_data_reg <= queue_mem[head_reg];
        if (push) begin
            queue_mem[tail_reg] <= req_id_reg;
        end
    end

    // Decision logic for one request.
    always_comb begin
        locked_next  = locked_reg;
        holder_next  = holder_reg;
        nest_next    = nest_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        push         = 1'b0;
        wake_valid_c = 1'b0;
        wake_id_c    = '0;
        is_holder    = locked_reg && (holder_reg == req_id_reg);
        status_c     = ST_GRANTED;
        if (req_type_reg == REQ_ACQUIRE) begin
            priority if (is_holder) begin
                if (&nest_reg) begin
                    status_c = ST_NEST_OVERFLOW;
                end else begin
                    nest_next = nest_reg + NEST_BITS'(1);
                    status_c  = ST_GRANTED;
                end
            end else if (!locked_reg) begin
                locked_next = 1'b1;
                holder_next = req_id_reg;
                nest_next   = NEST_BITS'(1);
                status_c    = ST_GRANTED;
            end else if (count_reg == FULL_CNT) begin
                status_c = ST_QUEUE_FULL;
            end else begin
                push       = cmd.execute;
                tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + PTR_W'(1);
                count_next = count_reg + CNT_W'(1);
                status_c   = ST_BLOCKED;
            end
        end else begin
            priority if (!is_holder) begin
                status_c = ST_NOT_HOLDER;
            end else if (nest_reg > NEST_BITS'(1)) begin
                nest_next = nest_reg - NEST_BITS'(1);
                status_c  = ST_STILL_HELD;
            end else if (count_reg == '0) begin
                locked_next = 1'b0;
                holder_next = '0;
                nest_next   = '0;
                status_c    = ST_FREED;
            end else begin
                holder_next  = head_data_reg;
                head_next    = (head_reg == LAST_SLOT) ? '0 : head_reg + PTR_W'(1);
                count_next   = count_reg - CNT_W'(1);
                nest_next    = NEST_BITS'(1);
                wake_valid_c = 1'b1;
                wake_id_c    = head_data_reg;
                status_c     = ST_HANDED;
            end
        end
    end

    // Lock state update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            locked_reg <= 1'b0;
            holder_reg <= '0;
            nest_reg   <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
        end else if (cmd.execute) begin
            locked_reg <= locked_next;
            holder_reg <= holder_next;
            nest_reg   <= nest_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
        end
    end

    // Result valid flag: set on execute, cleared when the result transfers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.execute) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            out_status_reg     <= status_c;
            out_wake_valid_reg <= wake_valid_c;
            out_wake_id_reg    <= wake_id_c;
            out_holder_reg     <= holder_next;
            out_locked_reg     <= locked_next;
        end
    end

    assign dp_status.out_stall = out_valid_reg && !m_ready;

    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_wake_valid = out_wake_valid_reg;
    assign m_wake_id    = out_wake_id_reg;
    assign m_holder_out = out_holder_reg;
    assign m_is_locked  = out_locked_reg;

endmodule

`default_nettype wire

// File: design/recursive_mutex_fifo_handoff.sv
// A request is captured when it transfers, and its result is loaded into the output register
// in the execute state, which waits while an earlier result is still stalled there.
// The unit takes no new request until the current one has executed: each request is
// captured in idle, then executed using the registered read of the waiter queue head.
// Reset (aresetn, synchronous, active low) frees the lock, empties the waiter
// queue pointers and count, and clears the result valid flag; queue memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module recursive_mutex_fifo_handoff
    import rmfh_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int NEST_BITS   = 8
)
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_req_type,
    input  wire logic [ID_W-1:0]     s_requester_id,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic                     m_wake_valid,
    output logic [ID_W-1:0]          m_wake_id,
    output logic [ID_W-1:0]          m_holder_out,
    output logic                     m_is_locked
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    // Sequencing of each request.
    rmfh_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // Lock state, waiter queue and result register.
    rmfh_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NEST_BITS   (NEST_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .dp_status      (dp_status),
        .s_req_type     (s_req_type),
        .s_requester_id (s_requester_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_wake_valid   (m_wake_valid),
        .m_wake_id      (m_wake_id),
        .m_holder_out   (m_holder_out),
        .m_is_locked    (m_is_locked)
    );

endmodule

`default_nettype wire

// File: design/rmfh_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rmfh_checker
    import rmfh_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire logic [STATUS_W-1:0] m_status,
    input  wire logic                m_wake_valid,
    input  wire logic [ID_W-1:0]     m_wake_id,
    input  wire logic [ID_W-1:0]     m_holder_out,
    input  wire logic                m_is_locked
);

    // A stalled result holds until it transfers.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)
            && $stable(m_wake_id) && $stable(m_holder_out)))
        else $error("result changed while stalled");

    // A wake is reported exactly for a handover.
    a_wake_handed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_wake_valid == (m_status == ST_HANDED)))
        else $error("wake flag disagrees with status");

    // Without a wake the wake identifier reads zero.
    a_wake_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_wake_valid) |-> (m_wake_id == '0))
        else $error("wake identifier set without a wake");

    // A free lock shows no holder.
    a_free_no_holder: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_locked) |-> (m_holder_out == '0))
        else $error("holder shown on a free lock");

    // Grants, still-held releases, handovers and blocked acquires leave the lock held; a free leaves it free.
    a_lock_vs_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (((m_status == ST_GRANTED) || (m_status == ST_STILL_HELD)
            || (m_status == ST_HANDED) || (m_status == ST_BLOCKED)) ? m_is_locked
            : ((m_status == ST_FREED) ? !m_is_locked : 1'b1)))
        else $error("lock flag disagrees with status");

endmodule

bind recursive_mutex_fifo_handoff rmfh_checker u_rmfh_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_wake_valid (m_wake_valid),
    .m_wake_id    (m_wake_id),
    .m_holder_out (m_holder_out),
    .m_is_locked  (m_is_locked)
);

`default_nettype wire

// File: tb/sv/rmfh_lock_monitor.sv
`timescale 1ns / 1ps

module rmfh_lock_monitor
    import rmfh_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int NEST_BITS   = 8
)
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire logic                s_req_type,
    input  wire logic [ID_W-1:0]     s_requester_id,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire logic [STATUS_W-1:0] m_status,
    input  wire logic                m_wake_valid,
    input  wire logic [ID_W-1:0]     m_wake_id,
    input  wire logic [ID_W-1:0]     m_holder_out,
    input  wire logic                m_is_locked,
    output int                       mismatches,
    output int                       outstanding
);

    localparam logic [NEST_BITS-1:0] NEST_CEILING = {NEST_BITS{1'b1}};

    // One predicted response of the lock unit.
    typedef struct packed {
        status_t         status;
        logic            wake_valid;
        logic [ID_W-1:0] wake_id;
        logic [ID_W-1:0] holder;
        logic            locked;
    } lock_outcome_t;

    // Predicted outcomes of accepted requests, oldest first.
    lock_outcome_t pending_outcomes[$];

    // Predicted lock state.
    logic                 lk_locked;
    logic [ID_W-1:0]      lk_holder;
    logic [NEST_BITS-1:0] lk_nest;
    logic [ID_W-1:0]      lk_waiters [QUEUE_DEPTH];
    int unsigned          lk_head;
    int unsigned          lk_tail;
    int unsigned          lk_count;

    // Apply one request to the predicted lock and return what the unit should report.
    function automatic lock_outcome_t resolve_request(logic kind, logic [ID_W-1:0] who);
        lock_outcome_t res;
        res.wake_valid = 1'b0;
        res.wake_id    = '0;
        if (kind == REQ_ACQUIRE) begin
            if (lk_locked && lk_holder == who) begin
                if (lk_nest == NEST_CEILING) begin
                    res.status = ST_NEST_OVERFLOW;
                end else begin
                    lk_nest    = lk_nest + 1'b1;
                    res.status = ST_GRANTED;
                end
            end else if (!lk_locked) begin
                lk_locked  = 1'b1;
                lk_holder  = who;
                lk_nest    = 1;
                res.status = ST_GRANTED;
            end else if (lk_count == QUEUE_DEPTH) begin
                res.status = ST_QUEUE_FULL;
            end else begin
                lk_waiters[lk_tail] = who;
                lk_tail    = (lk_tail + 1) % QUEUE_DEPTH;
                lk_count   = lk_count + 1;
                res.status = ST_BLOCKED;
            end
        end else begin
            if (!lk_locked || lk_holder != who) begin
                res.status = ST_NOT_HOLDER;
            end else if (lk_nest > 1) begin
                lk_nest    = lk_nest - 1'b1;
                res.status = ST_STILL_HELD;
            end else if (lk_count == 0) begin
                lk_locked  = 1'b0;
                lk_holder  = '0;
                lk_nest    = '0;
                res.status = ST_FREED;
            end else begin
                // The oldest waiter takes the lock with a count of one.
                lk_holder      = lk_waiters[lk_head];
                lk_head        = (lk_head + 1) % QUEUE_DEPTH;
                lk_count       = lk_count - 1;
                lk_nest        = 1;
                res.wake_valid = 1'b1;
                res.wake_id    = lk_holder;
                res.status     = ST_HANDED;
            end
        end
        res.locked = lk_locked;
        res.holder = lk_locked ? lk_holder : '0;
        return res;
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches = mismatches + 1;
    endtask

    task automatic check_field(string name, logic [ID_W-1:0] got, logic [ID_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    // Compare each result transfer with the oldest prediction, then predict each request transfer.
    always @(posedge aclk) begin
        lock_outcome_t want;
        if (!aresetn) begin
            lk_locked = 1'b0;
            lk_holder = '0;
            lk_nest   = '0;
            lk_head   = 0;
            lk_tail   = 0;
            lk_count  = 0;
            pending_outcomes.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_outcomes.size() == 0) begin
                    report_mismatch($sformatf("result transfer with no pending request, status %0d",
                                              m_status));
                end else begin
                    want = pending_outcomes.pop_front();
                    check_field("status", m_status, want.status);
                    check_field("wake_valid", m_wake_valid, want.wake_valid);
                    check_field("wake_id", m_wake_id, want.wake_id);
                    check_field("holder_out", m_holder_out, want.holder);
                    check_field("is_locked", m_is_locked, want.locked);
                end
            end
            if (s_valid && s_ready) begin
                pending_outcomes.push_back(resolve_request(s_req_type, s_requester_id));
            end
        end
        outstanding = pending_outcomes.size();
    end

endmodule

// File: tb/sv/tb_recursive_mutex_fifo_handoff.sv
`timescale 1ns / 1ps

module tb_recursive_mutex_fifo_handoff;
    import rmfh_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int NEST_BITS    = 8;
    localparam int NEST_TOP     = (1 << NEST_BITS) - 1;
    localparam int RANDOM_ITEMS = 800;
    localparam int IDLE_LIMIT   = 400;
    localparam int TAIL_CYCLES  = 20;

    // Traffic mixes for the random part.
    typedef enum int {
        MIX_BALANCED,
        MIX_FLOOD,
        MIX_NESTING
    } traffic_mix_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_req_type;
    logic [ID_W-1:0]     s_requester_id;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic                m_wake_valid;
    logic [ID_W-1:0]     m_wake_id;
    logic [ID_W-1:0]     m_holder_out;
    logic                m_is_locked;
    int                  mismatches;
    int                  outstanding;

    // The lock as the issued requests will leave it; used only to shape stimulus.
    logic            owned;
    logic [ID_W-1:0] owner;
    int              owner_depth;
    logic [ID_W-1:0] queued_ids[$];

    logic [ID_W-1:0] id_pool [8];
    bit              send_calm;

    recursive_mutex_fifo_handoff #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NEST_BITS   (NEST_BITS)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_requester_id (s_requester_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_wake_valid   (m_wake_valid),
        .m_wake_id      (m_wake_id),
        .m_holder_out   (m_holder_out),
        .m_is_locked    (m_is_locked)
    );

    rmfh_lock_monitor #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NEST_BITS   (NEST_BITS)
    ) u_lock_monitor (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_requester_id (s_requester_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_wake_valid   (m_wake_valid),
        .m_wake_id      (m_wake_id),
        .m_holder_out   (m_holder_out),
        .m_is_locked    (m_is_locked),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Idle cycles before the next transfer; calm stretches have none.
    function automatic int pick_gap(inout bit calm);
        if ($urandom_range(0, 63) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    // Half the time a thread from a small pool, so the same threads collide and requeue.
    function automatic logic [ID_W-1:0] pick_id();
        logic [ID_W-1:0] fresh;
        fresh = $urandom();
        return ($urandom_range(0, 1) != 0) ? id_pool[$urandom_range(0, 7)] : fresh;
    endfunction

    // Issue one request transfer, keeping the stimulus view of the lock current.
    task automatic post_request(input logic kind, input logic [ID_W-1:0] who);
        int gap;
        if (kind == REQ_ACQUIRE) begin
            if (owned && owner == who) begin
                if (owner_depth < NEST_TOP) owner_depth++;
            end else if (!owned) begin
                owned       = 1'b1;
                owner       = who;
                owner_depth = 1;
            end else if (queued_ids.size() < QUEUE_DEPTH) begin
                queued_ids.push_back(who);
            end
        end else if (owned && owner == who) begin
            if (owner_depth > 1) begin
                owner_depth--;
            end else if (queued_ids.size() == 0) begin
                owned = 1'b0;
            end else begin
                owner       = queued_ids.pop_front();
                owner_depth = 1;
            end
        end

        gap = pick_gap(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= kind;
        s_requester_id <= who;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold off the sender until every predicted result has been transferred.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        @(posedge aclk);
    endtask

    // Result side: random stalls, with ready then held after each until a transfer happens.
    initial begin
        int  stall;
        bit  calm;
        calm = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = pick_gap(calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Watchdog on cycles without any transfer.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("status: fail");
        $finish;
    end

    // Request stimulus and verdict.
    initial begin
        traffic_mix_t mix;
        int           pick;
        int           rel_w;
        int           nest_w;
        int           arr_w;

        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_req_type     <= REQ_ACQUIRE;
        s_requester_id <= '0;
        owned       = 1'b0;
        owner       = '0;
        owner_depth = 0;
        send_calm   = 1'b0;
        mix         = MIX_BALANCED;
        rel_w       = 0;
        nest_w      = 0;
        arr_w       = 0;
        id_pool[0]  = '0;
        id_pool[1]  = '1;
        for (int k = 2; k < 8; k++) id_pool[k] = $urandom();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Releases by a non-holder on a free and on a held lock, nesting, requeued waiters.
        post_request(REQ_RELEASE, '0);
        post_request(REQ_ACQUIRE, '0);
        post_request(REQ_ACQUIRE, '0);
        post_request(REQ_RELEASE, '1);
        post_request(REQ_ACQUIRE, '1);
        post_request(REQ_ACQUIRE, '1);
        post_request(REQ_RELEASE, '0);
        post_request(REQ_RELEASE, '0);
        post_request(REQ_RELEASE, '1);
        post_request(REQ_RELEASE, '1);
        post_request(REQ_ACQUIRE, '1);

        // Fill the waiter queue, then one more acquire finds it full.
        for (int k = 0; k <= QUEUE_DEPTH; k++) begin
            post_request(REQ_ACQUIRE, ID_W'(k * 15));
        end

        wait_for_results();

        // Nest the holder to the ceiling, overflow twice, unwind, then hand off.
        while (owner_depth < NEST_TOP) post_request(REQ_ACQUIRE, owner);
        repeat (2) post_request(REQ_ACQUIRE, owner);
        while (owner_depth > 1) post_request(REQ_RELEASE, owner);
        post_request(REQ_RELEASE, owner);

        // Mostly well-formed lock traffic, with noise from arbitrary threads.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                mix = traffic_mix_t'($urandom_range(0, 2));
                case (mix)
                    MIX_FLOOD: begin
                        rel_w = 15; nest_w = 10; arr_w = 60;
                    end
                    MIX_NESTING: begin
                        rel_w = 25; nest_w = 45; arr_w = 15;
                    end
                    default: begin
                        rel_w = 35; nest_w = 15; arr_w = 30;
                    end
                endcase
            end
            if ($urandom_range(0, 199) == 0) begin
                wait_for_results();
            end
            pick = $urandom_range(0, 99);
            if (!owned) begin
                post_request((pick < 75) ? REQ_ACQUIRE : REQ_RELEASE, pick_id());
            end else if (pick < rel_w) begin
                post_request(REQ_RELEASE, owner);
            end else if (pick < rel_w + nest_w) begin
                post_request(REQ_ACQUIRE, owner);
            end else if (pick < rel_w + nest_w + arr_w) begin
                post_request(REQ_ACQUIRE, pick_id());
            end else begin
                post_request(($urandom_range(0, 1) != 0) ? REQ_RELEASE : REQ_ACQUIRE,
                             ID_W'($urandom()));
            end
        end

        // Drain, then watch a while for stray results.
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
design/rmfh_pkg.sv
design/rmfh_ctrl.sv
design/rmfh_datapath.sv
design/recursive_mutex_fifo_handoff.sv
design/rmfh_checker.sv
tb/sv/rmfh_lock_monitor.sv
tb/sv/tb_recursive_mutex_fifo_handoff.sv
